// ----- sv/modexp_pkg.sv -----
package modexp_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // (a + b) mod m for a, b below m; no intermediate value leaves WIDTH bits.
  function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
    word_t gap;
    gap = m - b;
    if (a >= gap) begin
      add_mod = a - gap;
    end else begin
      add_mod = a + b;
    end
  endfunction

  // One step of the interleaved modular multiplication: double, then add.
  function automatic word_t mul_step(input word_t acc, input word_t addend,
                                     input logic add_en, input word_t m);
    word_t dbl;
    dbl = add_mod(acc, acc, m);
    if (add_en) begin
      mul_step = add_mod(dbl, addend, m);
    end else begin
      mul_step = dbl;
    end
  endfunction

endpackage

// ----- sv/modular_exponentiation_top.sv -----
// Modular exponentiation by left-to-right square-and-multiply. A request is taken when start
// is high and busy is low; the result appears on out_power_result for exactly one cycle with
// out_valid high, and the receiver cannot stall it. All arithmetic runs through one shared
// bit-serial modular multiply step that handles one multiplier bit per cycle. The base is
// first reduced, then every exponent bit costs a squaring and each set bit a further
// multiplication, and busy falls in the cycle after the strobe. With a modulus of zero
// the result is 0 and arrives in the cycle after the request is taken. The modulus is
// written through cfg_wr_en and cfg_wr_data and resets to 1; the user must write it only
// while the block is idle, which the block itself does not enforce.
module modular_exponentiation_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [modexp_pkg::WIDTH-1:0] in_base,
  input  logic [modexp_pkg::WIDTH-1:0] in_exponent,
  output logic                     out_valid,
  output logic [modexp_pkg::WIDTH-1:0] out_power_result,
  input  logic                     cfg_wr_en,
  input  logic [modexp_pkg::WIDTH-1:0] cfg_wr_data
);
  import modexp_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_SQR    = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam cnt_t CNT_TOP = cnt_t'(WIDTH - 1);

  logic [2:0] state_r, state_nxt;
  word_t      modulus_r;
  word_t      res_r, res_nxt;
  word_t      base_r, base_nxt;
  word_t      mulacc_r, mulacc_nxt;
  word_t      mulr_r, mulr_nxt;
  word_t      exp_r, exp_nxt;
  cnt_t       bit_cnt_r, bit_cnt_nxt;
  cnt_t       exp_cnt_r, exp_cnt_nxt;

  word_t      addend;
  word_t      step_out;

  // The shared unit; during base reduction the addend is one, so the step builds
  // (2r + bit) mod m one base bit at a time.
  assign addend   = (state_r == ST_REDUCE) ? word_t'(1) : res_r;
  assign step_out = mul_step(mulacc_r, addend, mulr_r[WIDTH-1], modulus_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= word_t'(1);
    end else if (cfg_wr_en) begin
      modulus_r <= cfg_wr_data;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    res_nxt     = res_r;
    base_nxt    = base_r;
    mulacc_nxt  = mulacc_r;
    mulr_nxt    = mulr_r;
    exp_nxt     = exp_r;
    bit_cnt_nxt = bit_cnt_r;
    exp_cnt_nxt = exp_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (modulus_r == '0) begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            res_nxt     = (modulus_r == word_t'(1)) ? '0 : word_t'(1);
            mulr_nxt    = in_base;
            mulacc_nxt  = '0;
            exp_nxt     = in_exponent;
            bit_cnt_nxt = CNT_TOP;
            exp_cnt_nxt = CNT_TOP;
            state_nxt   = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        mulacc_nxt  = step_out;
        mulr_nxt    = mulr_r << 1;
        bit_cnt_nxt = bit_cnt_r - cnt_t'(1);
        if (bit_cnt_r == '0) begin
          base_nxt    = step_out;
          mulr_nxt    = res_r;
          mulacc_nxt  = '0;
          bit_cnt_nxt = CNT_TOP;
          state_nxt   = ST_SQR;
        end
      end
      ST_SQR, ST_MUL: begin
        mulacc_nxt  = step_out;
        mulr_nxt    = mulr_r << 1;
        bit_cnt_nxt = bit_cnt_r - cnt_t'(1);
        if (bit_cnt_r == '0) begin
          res_nxt     = step_out;
          mulacc_nxt  = '0;
          bit_cnt_nxt = CNT_TOP;
          if (state_r == ST_SQR && exp_r[WIDTH-1]) begin
            mulr_nxt  = base_r;
            state_nxt = ST_MUL;
          end else if (exp_cnt_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            exp_nxt     = exp_r << 1;
            exp_cnt_nxt = exp_cnt_r - cnt_t'(1);
            mulr_nxt    = step_out;
            state_nxt   = ST_SQR;
          end
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    base_r    <= base_nxt;
    mulacc_r  <= mulacc_nxt;
    mulr_r    <= mulr_nxt;
    exp_r     <= exp_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    exp_cnt_r <= exp_cnt_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = (state_r == ST_DONE);
  assign out_power_result = res_r;

`ifndef ASSERT_OFF
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted request");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe lasted more than one cycle");

  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (modulus_r != '0) |-> out_power_result < modulus_r)
    else $error("result not reduced below the modulus");

  a_accumulator_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQR || state_r == ST_MUL) |-> mulacc_r < modulus_r)
    else $error("partial product left the residue range");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import modexp_pkg::*;

  // Longest quiet stretch of a correct run is one full exponentiation plus the sender's
  // gap, or the drain at the end; the limit is several times that.
  localparam int IDLE_LIMIT   = 12000;
  localparam int DRAIN_CYCLES = 2100;
  localparam int MAX_GAP      = 18;

  typedef struct packed {
    word_t base;
    word_t exponent;
  } exp_request_t;

  logic  clk         = 1'b0;
  logic  rst_n       = 1'b0;
  logic  start       = 1'b0;
  logic  busy;
  word_t in_base     = '0;
  word_t in_exponent = '0;
  logic  out_valid;
  word_t out_power_result;
  logic  cfg_wr_en   = 1'b0;
  word_t cfg_wr_data = '0;

  exp_request_t pending_requests[$];
  word_t        expected_powers[$];
  word_t        modulus_now;
  int           gap_left     = 0;
  bit           idle_enable  = 1'b0;
  int           idle_cycles  = 0;
  int           error_count  = 0;

  modular_exponentiation_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_base          (in_base),
    .in_exponent      (in_exponent),
    .out_valid        (out_valid),
    .out_power_result (out_power_result),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Left-to-right square-and-multiply with exact 64-bit products.
  function automatic word_t power_mod(input word_t base, input word_t exponent,
                                      input word_t modulus);
    longint unsigned m;
    longint unsigned b;
    longint unsigned acc;
    if (modulus == '0) begin
      return '0;
    end
    m   = modulus;
    b   = base % m;
    acc = 1 % m;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      acc = (acc * acc) % m;
      if (exponent[i]) begin
        acc = (acc * b) % m;
      end
    end
    return acc[WIDTH-1:0];
  endfunction

  // Driver: presents queued requests, holding start until the block takes one.
  always @(posedge clk) begin
    exp_request_t req;
    bit           accepted;
    accepted = 1'b0;
    if (!rst_n) begin
      start       <= 1'b0;
      modulus_now =  word_t'(1);
      gap_left    =  0;
    end else begin
      if (cfg_wr_en) begin
        modulus_now = cfg_wr_data;
      end
      if (start && !busy) begin
        expected_powers = {expected_powers, power_mod(in_base, in_exponent, modulus_now)};
        gap_left = idle_enable ? $urandom_range(0, MAX_GAP) : 0;
        accepted = 1'b1;
      end
      if (!(start && busy)) begin
        if (gap_left > 0 || pending_requests.size() == 0) begin
          // The gap only runs down while the block is free, so it lands after the result.
          if (gap_left > 0 && !busy && !accepted) begin
            gap_left--;
          end
          start <= 1'b0;
        end else begin
          req = pending_requests.pop_front();
          in_base     <= req.base;
          in_exponent <= req.exponent;
          start       <= 1'b1;
        end
      end
    end
  end

  // Monitor: every strobe is matched against the oldest outstanding request.
  always @(posedge clk) begin
    word_t want;
    if (rst_n && out_valid) begin
      if (expected_powers.size() == 0) begin
        $error("power_result with no request outstanding: actual %0h", out_power_result);
        error_count++;
      end else begin
        want = expected_powers.pop_front();
        if (out_power_result !== want) begin
          $error("power_result mismatch: expected %0h, actual %0h", want, out_power_result);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The state is sampled at the falling edge, once the driver has settled.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_requests.size() != 0 || expected_powers.size() != 0 || start || busy) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  task automatic set_modulus(input word_t value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic queue_request(input word_t base, input word_t exponent);
    exp_request_t req;
    req.base     = base;
    req.exponent = exponent;
    pending_requests = {pending_requests, req};
  endtask

  task automatic queue_random(input int count, input word_t modulus);
    word_t b;
    word_t e;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 5))
        0:       b = $urandom_range(0, 3);
        1:       b = (modulus != '0) ? $urandom % modulus : $urandom;
        2:       b = modulus - 1;
        3:       b = '1;
        default: b = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0:       e = $urandom_range(0, 16);
        1:       e = word_t'(1) << $urandom_range(0, WIDTH - 1);
        2:       e = ~(word_t'(1) << $urandom_range(0, WIDTH - 1));
        3:       e = '1;
        4:       e = $urandom & $urandom;
        default: e = $urandom;
      endcase
      queue_request(b, e);
    end
  endtask

  initial begin
    word_t m;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Modulus left at its reset value of one.
    queue_request('1, '1);
    queue_request(5, 0);
    queue_request(0, 0);

    set_modulus(3233);
    idle_enable = 1'b1;
    queue_request(0, 0);
    queue_request(0, 1);
    queue_request(1, '1);
    queue_request('1, 0);
    queue_request('1, '1);
    queue_request(3233, 5);
    queue_request(3232, 2);
    queue_request(65, 17);
    queue_request(2790, 2753);
    queue_request(12345, 1);

    // A zero modulus returns zero at once.
    set_modulus(0);
    queue_request('1, '1);
    queue_request(7, 0);
    queue_request(0, 0);

    set_modulus(1);
    queue_request('1, 12345);
    queue_request(0, 0);

    set_modulus('1);
    idle_enable = 1'b0;
    queue_request(32'hFFFF_FFFE, 2);
    queue_request('1, '1);
    queue_request(2, 31);
    queue_request(2, 32);
    queue_request(3, '1);

    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 7))
        0:       m = $urandom_range(0, 1);
        1:       m = $urandom_range(2, 255);
        2:       m = $urandom | 32'h8000_0001;
        3:       m = $urandom_range(256, 65535);
        default: m = $urandom;
      endcase
      set_modulus(m);
      idle_enable = (phase % 3 != 0);
      queue_random(22, m);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
